// File: rtl/core/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants of the integer to ASCII converter
// Command and status bundles between controller and datapath, character
// codes and the digit-to-character mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] RADIX_DEC = 6'd10;
  localparam logic [5:0] DIGIT_MAX = 6'd9;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_A     = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Controller to datapath.
  typedef struct packed {
    logic load;         // capture a new transaction
    logic div_step;     // one restoring division step
    logic store_digit;  // write the remainder character, clear the remainder
    logic store_sign;   // write the minus sign
    logic rd_issue;     // read the next character, most significant first
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_bad;     // radix on the input port is out of range
    logic mag_zero;   // magnitude on the input port is zero
    logic div_last;   // current division step is the final one
    logic quot_zero;  // stored quotient is zero
    logic negative;   // a minus sign is pending
    logic cnt_zero;   // no characters left in the store
  } stat_t;

  function automatic logic radix_ok(input logic [5:0] radix);
    radix_ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  endfunction

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    if (d > DIGIT_MAX) begin
      digit_char = CHAR_A + {2'b00, d} - {2'b00, DIGIT_MAX} - 8'd1;
    end else begin
      digit_char = CHAR_ZERO + {2'b00, d};
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/integer_to_ascii_radix_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top: integer to ASCII text in radix 2 to 36
// Emits the characters of a number, most significant first, with a minus
// sign for negative values in radix 10 and an error result for a bad radix.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   input    in         in_valid_i/in_ready_o  value_i, radix_i
//   output   out        out_valid_o/out_ready_i character_o, last_char_o,
//                                              bad_radix_o
//
// One transaction is converted at a time. Each digit comes from the
// bit-serial divider and is written to the store, the sign after the
// digits; each character then goes through the registered store read
// port and is held on the output until taken. A bad radix gives its
// single result in the cycle after acceptance. Reset clears the sequencer
// and the datapath registers but the read register; the store and the read
// register need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_radix_top #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] value_i,
  input  wire logic [5:0]  radix_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       character_o,
  output logic             last_char_o,
  output logic             bad_radix_o
);

  itoa_pkg::cmd_t  cmd;
  itoa_pkg::stat_t stat;
  logic [7:0]      dp_char;

  itoa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_last_o  (last_char_o),
    .out_err_o   (bad_radix_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  itoa_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (value_i),
    .radix_i (radix_i),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .char_o  (dp_char)
  );

  assign character_o = bad_radix_o ? itoa_pkg::CHAR_NUL : dp_char;

  // The block never takes input while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // A bad radix is answered in the next cycle with a single error result.
  a_bad_radix_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !itoa_pkg::radix_ok(radix_i))
    |=> (out_valid_o && bad_radix_o && last_char_o &&
         (character_o == itoa_pkg::CHAR_NUL)))
    else $error("bad radix not answered by an error result");

  // After the final character the block is ready for the next transaction.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_char_o) |=> in_ready_o)
    else $error("block not ready after the final character");

  // At most one datapath command is issued in any cycle.
  a_dp_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.div_step, cmd.store_digit, cmd.store_sign, cmd.rd_issue}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// File: rtl/core/itoa_ctrl.sv
// ----------------------------------------------------------------------------
// itoa_ctrl: conversion sequencer
// Steps the datapath through the division loop, the sign and the output
// phase, and drives the handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic                out_last_o,
  output logic                out_err_o,
  input  wire itoa_pkg::stat_t stat_i,
  output itoa_pkg::cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_STORE = 7'b0000100,
    ST_SIGN  = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_SHOW  = 7'b0100000,
    ST_ERR   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.in_bad) begin
            state_d = ST_ERR;
          end else if (stat_i.mag_zero) begin
            state_d = ST_STORE;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store_digit = 1'b1;
        if (!stat_i.quot_zero) begin
          state_d = ST_DIV;
        end else if (stat_i.negative) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_SIGN: begin
        cmd_o.store_sign = 1'b1;
        state_d          = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready_i) begin
          state_d = stat_i.cnt_zero ? ST_IDLE : ST_READ;
        end
      end
      ST_ERR: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_SHOW) || (state_q == ST_ERR);
  assign out_err_o   = (state_q == ST_ERR);
  // The read already moved the count past the shown character.
  assign out_last_o  = (state_q == ST_ERR) || ((state_q == ST_SHOW) && stat_i.cnt_zero);

endmodule

`default_nettype wire

// File: rtl/core/itoa_dp.sv
// ----------------------------------------------------------------------------
// itoa_dp: conversion datapath
// Bit-serial restoring divider by the radix, the character store and the
// registered read port that feeds the output.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_dp #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [63:0]   value_i,
  input  wire logic [5:0]    radix_i,
  input  wire itoa_pkg::cmd_t cmd_i,
  output itoa_pkg::stat_t    stat_o,
  output logic [7:0]         char_o
);

  localparam int unsigned IW = $clog2(VALUE_BITS);
  localparam int unsigned CW = $clog2(VALUE_BITS + 1);
  localparam int unsigned BW = $clog2(VALUE_BITS);
  localparam logic [BW-1:0] BIT_LAST = BW'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0] v_in, mag_in;
  logic                  neg_in;

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [5:0]            rem_q, rem_d;
  logic [5:0]            radix_q;
  logic                  neg_q;
  logic [BW-1:0]         bit_q, bit_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [7:0]            rd_q;
  logic [7:0]            store_q [VALUE_BITS];

  logic [6:0]            trial, trial_sub;
  logic                  ge;
  logic [CW-1:0]         cnt_dec;

  assign v_in   = value_i[VALUE_BITS-1:0];
  assign neg_in = (radix_i == itoa_pkg::RADIX_DEC) && v_in[VALUE_BITS-1];
  assign mag_in = neg_in ? (~v_in + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v_in;

  // Shift the next dividend bit into the partial remainder.
  assign trial     = {rem_q, mag_q[VALUE_BITS-1]};
  assign trial_sub = trial - {1'b0, radix_q};
  assign ge        = (trial >= {1'b0, radix_q});
  assign cnt_dec   = cnt_q - {{(CW-1){1'b0}}, 1'b1};

  always_comb begin
    mag_d = mag_q;
    rem_d = rem_q;
    bit_d = bit_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      mag_d = mag_in;
      rem_d = '0;
      bit_d = '0;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      mag_d = {mag_q[VALUE_BITS-2:0], ge};
      rem_d = ge ? trial_sub[5:0] : trial[5:0];
      bit_d = (bit_q == BIT_LAST) ? '0 : bit_q + {{(BW-1){1'b0}}, 1'b1};
    end else if (cmd_i.store_digit) begin
      rem_d = '0;
      cnt_d = cnt_q + {{(CW-1){1'b0}}, 1'b1};
    end else if (cmd_i.store_sign) begin
      cnt_d = cnt_q + {{(CW-1){1'b0}}, 1'b1};
    end else if (cmd_i.rd_issue) begin
      cnt_d = cnt_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q   <= '0;
      cnt_q   <= '0;
      mag_q   <= '0;
      rem_q   <= '0;
      radix_q <= '0;
      neg_q   <= 1'b0;
    end else begin
      bit_q <= bit_d;
      cnt_q <= cnt_d;
      mag_q <= mag_d;
      rem_q <= rem_d;
      if (cmd_i.load) begin
        radix_q <= radix_i;
        neg_q   <= neg_in;
      end
    end
  end

  // Character store, written at the fill count, read one below it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_digit) begin
      store_q[cnt_q[IW-1:0]] <= itoa_pkg::digit_char(rem_q);
    end else if (cmd_i.store_sign) begin
      store_q[cnt_q[IW-1:0]] <= itoa_pkg::CHAR_MINUS;
    end
    if (cmd_i.rd_issue) begin
      rd_q <= store_q[cnt_dec[IW-1:0]];
    end
  end

  assign stat_o.in_bad    = !itoa_pkg::radix_ok(radix_i);
  assign stat_o.mag_zero  = (mag_in == '0);
  assign stat_o.div_last  = (bit_q == BIT_LAST);
  assign stat_o.quot_zero = (mag_q == '0);
  assign stat_o.negative  = neg_q;
  assign stat_o.cnt_zero  = (cnt_q == '0);
  assign char_o           = rd_q;

endmodule

`default_nettype wire
